@@ rtl/lfuc_pkg.sv @@
`default_nettype none

package lfuc_pkg;

	// Slot count and use counter width of the cache.
	localparam int CAPACITY = 16;
	localparam int USE_BITS = 16;

	// Fixed field widths.
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int TOUCH_W = 32;
	localparam int CFG_W   = 5;

	// Derived widths: slot index, occupancy count, and a width wide enough
	// to compare the occupancy count against the capacity register.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [VAL_W-1:0]    value;
		logic [USE_BITS-1:0] use_cnt;
		logic [TOUCH_W-1:0]  last_touch;
	} entry_t;

	localparam int ENT_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Control into the compare unit, built by the top level from the sequencer.
	typedef struct packed {
		logic               clear;
		logic               eval;
		logic [IDX_W-1:0]   idx;
		logic               slot_valid;
		logic [KEY_W-1:0]   key;
		logic [TOUCH_W-1:0] touch_now;
	} scan_ctl_t;

	// Outcome of a full scan.
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] match_idx;
		entry_t           match_ent;
		logic             have_free;
		logic [IDX_W-1:0] free_idx;
		logic [IDX_W-1:0] victim_idx;
	} scan_res_t;

endpackage

`default_nettype wire

@@ rtl/lfuc_if.sv @@
`default_nettype none

interface lfuc_req_if;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [lfuc_pkg::KEY_W-1:0] key;
	logic [lfuc_pkg::VAL_W-1:0] value;

	modport source (output valid, output action, output key, output value, input ready);
	modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lfuc_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic [lfuc_pkg::VAL_W-1:0] read_value;
	logic                      evicted;

	modport source (output valid, output hit, output read_value, output evicted, input ready);
	modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

`default_nettype wire

@@ rtl/lfuc_ram.sv @@
`default_nettype none

module lfuc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/lfuc_scan.sv @@
`default_nettype none

// Compare unit shared by every slot of a scan: one slot per cycle is checked
// for a key match, for being free, and against the best victim so far.
module lfuc_scan (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lfuc_pkg::scan_ctl_t ctl,
	input  wire lfuc_pkg::entry_t    ent,
	output lfuc_pkg::scan_res_t      res
);

	logic                           hit_q;
	logic                           free_q;
	logic                           found_q;
	logic [lfuc_pkg::IDX_W-1:0]     match_idx_q;
	lfuc_pkg::entry_t               match_ent_q;
	logic [lfuc_pkg::IDX_W-1:0]     free_idx_q;
	logic [lfuc_pkg::IDX_W-1:0]     best_idx_q;
	logic [lfuc_pkg::USE_BITS-1:0]  best_use_q;
	logic [lfuc_pkg::TOUCH_W-1:0]   best_age_q;

	logic [lfuc_pkg::TOUCH_W-1:0]   age;
	logic                           better;
	logic                           key_match;

	// Age wraps with the touch counter; a larger age is older.
	assign age       = ctl.touch_now - ent.last_touch;
	assign key_match = !hit_q && (ent.key == ctl.key);
	assign better    = !found_q || (ent.use_cnt < best_use_q) ||
	                   ((ent.use_cnt == best_use_q) && (age > best_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (ctl.eval) begin
			if (ctl.slot_valid) begin
				if (key_match) begin
					hit_q <= 1'b1;
				end
				if (better) begin
					found_q <= 1'b1;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			if (ctl.slot_valid) begin
				if (key_match) begin
					match_idx_q <= ctl.idx;
					match_ent_q <= ent;
				end
				if (better) begin
					best_idx_q <= ctl.idx;
					best_use_q <= ent.use_cnt;
					best_age_q <= age;
				end
			end else if (!free_q) begin
				free_idx_q <= ctl.idx;
			end
		end
	end

	always_comb begin
		res.hit        = hit_q;
		res.match_idx  = match_idx_q;
		res.match_ent  = match_ent_q;
		res.have_free  = free_q;
		res.free_idx   = free_idx_q;
		res.victim_idx = best_idx_q;
	end

endmodule

`default_nettype wire

@@ rtl/lfuc_seq.sv @@
`default_nettype none

// Sequencer: accepts a request, walks the slot RAM one address per cycle,
// then commits the write-back and the response.
module lfuc_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire logic                last_eval,
	input  wire logic                rsp_busy,
	output logic                     accept,
	output logic                     issue,
	output logic                     finish_go,
	output logic [lfuc_pkg::IDX_W-1:0] rd_addr
);

	lfuc_pkg::state_t             state_q, state_d;
	logic [lfuc_pkg::CNT_W-1:0]   cnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lfuc_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = lfuc_pkg::ST_SCAN;
				end
			end
			lfuc_pkg::ST_SCAN: begin
				if (last_eval) begin
					state_d = lfuc_pkg::ST_FINISH;
				end
			end
			lfuc_pkg::ST_FINISH: begin
				if (!rsp_busy) begin
					state_d = lfuc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfuc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		issue     = 1'b0;
		finish_go = 1'b0;
		case (state_q)
			lfuc_pkg::ST_IDLE: begin
				req_ready = 1'b1;
			end
			lfuc_pkg::ST_SCAN: begin
				issue = (cnt_q < lfuc_pkg::CNT_W'(lfuc_pkg::CAPACITY));
			end
			lfuc_pkg::ST_FINISH: begin
				finish_go = !rsp_busy;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	assign accept  = req_ready && req_valid;
	assign rd_addr = cnt_q[lfuc_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfuc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + lfuc_pkg::CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/lfu_cache_lru_tiebreak.sv @@
`default_nettype none

// Channel     Direction  Transfer condition        Payload
// req         in         req.valid && req.ready    action, key, value
// rsp         out        rsp.valid && rsp.ready    hit, read_value, evicted
// cfg_we      in         cfg_we high at clk edge   cfg_wdata (capacity_in_use)
//
// A request is first transferred, then every slot is streamed out of the
// slot RAM through the one compare unit, and last the block writes back
// and loads the response register.
// The block is ready only while idle. Reset clears the valid bits, the touch
// counter, the occupancy count and sets the capacity register to 16; the RAM
// contents are not cleared. A response that is not taken holds the
// write-back cycle until the response register frees up.
module lfu_cache_lru_tiebreak (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lfuc_pkg::CFG_W-1:0]    cfg_wdata,
	lfuc_req_if.sink                           req,
	lfuc_rsp_if.source                         rsp
);

	// Request held for the whole scan.
	logic                           act_q;
	logic [lfuc_pkg::KEY_W-1:0]     key_q;
	logic [lfuc_pkg::VAL_W-1:0]     val_q;

	// Block state outside the slot RAM.
	logic [lfuc_pkg::CFG_W-1:0]     cap_q;
	logic [lfuc_pkg::TOUCH_W-1:0]   touch_q;
	logic [lfuc_pkg::CNT_W-1:0]     occ_q;
	logic [lfuc_pkg::CAPACITY-1:0]  valid_q;

	// Response register.
	logic                           rsp_valid_q;
	logic                           rsp_hit_q;
	logic [lfuc_pkg::VAL_W-1:0]     rsp_value_q;
	logic                           rsp_evicted_q;

	// Read pipeline: the slot whose RAM data arrives this cycle.
	logic                           eval_s1;
	logic [lfuc_pkg::IDX_W-1:0]     eval_idx_s1;

	logic                           accept;
	logic                           issue;
	logic                           finish_go;
	logic                           last_eval;
	logic [lfuc_pkg::IDX_W-1:0]     rd_addr;
	logic [lfuc_pkg::ENT_W-1:0]     rd_data;
	lfuc_pkg::entry_t               rd_ent;

	lfuc_pkg::scan_ctl_t            scan_ctl;
	lfuc_pkg::scan_res_t            scan_res;

	logic [lfuc_pkg::CMP_W-1:0]     cap_ext;
	logic [lfuc_pkg::CMP_W-1:0]     cap_eff;
	logic                           is_put;
	logic                           full;
	logic                           wr_en;
	logic                           fill;
	logic [lfuc_pkg::IDX_W-1:0]     wr_idx;
	lfuc_pkg::entry_t               wr_ent;
	logic [lfuc_pkg::TOUCH_W-1:0]   touch_next;

	lfuc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.last_eval (last_eval),
		.rsp_busy  (rsp_valid_q && !rsp.ready),
		.accept    (accept),
		.issue     (issue),
		.finish_go (finish_go),
		.rd_addr   (rd_addr)
	);

	lfuc_ram #(
		.WIDTH (lfuc_pkg::ENT_W),
		.DEPTH (lfuc_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_ent),
		.re    (issue),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign rd_ent    = rd_data;
	assign last_eval = eval_s1 && (eval_idx_s1 == lfuc_pkg::IDX_W'(lfuc_pkg::CAPACITY - 1));

	always_comb begin
		scan_ctl.clear      = accept;
		scan_ctl.eval       = eval_s1;
		scan_ctl.idx        = eval_idx_s1;
		scan_ctl.slot_valid = valid_q[eval_idx_s1];
		scan_ctl.key        = key_q;
		scan_ctl.touch_now  = touch_q;
	end

	lfuc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.ent    (rd_ent),
		.res    (scan_res)
	);

	// Effective capacity is the register clamped to 1..CAPACITY.
	assign cap_ext = lfuc_pkg::CMP_W'(cap_q);
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = lfuc_pkg::CMP_W'(1);
		end else if (cap_ext > lfuc_pkg::CMP_W'(lfuc_pkg::CAPACITY)) begin
			cap_eff = lfuc_pkg::CMP_W'(lfuc_pkg::CAPACITY);
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign is_put     = (act_q == lfuc_pkg::ACT_PUT);
	assign full       = (lfuc_pkg::CMP_W'(occ_q) >= cap_eff) || !scan_res.have_free;
	assign wr_en      = finish_go && (scan_res.hit || is_put);
	assign fill       = finish_go && is_put && !scan_res.hit && !full;
	assign touch_next = touch_q + lfuc_pkg::TOUCH_W'(1);

	// A hit bumps the count (saturating) and recency of the matched slot; a put
	// miss writes a fresh entry into the free slot or over the victim.
	always_comb begin
		if (scan_res.hit) begin
			wr_idx         = scan_res.match_idx;
			wr_ent.key     = scan_res.match_ent.key;
			wr_ent.value   = is_put ? val_q : scan_res.match_ent.value;
			wr_ent.use_cnt = (scan_res.match_ent.use_cnt == '1) ?
			                 scan_res.match_ent.use_cnt :
			                 scan_res.match_ent.use_cnt + lfuc_pkg::USE_BITS'(1);
		end else begin
			wr_idx         = full ? scan_res.victim_idx : scan_res.free_idx;
			wr_ent.key     = key_q;
			wr_ent.value   = val_q;
			wr_ent.use_cnt = lfuc_pkg::USE_BITS'(1);
		end
		wr_ent.last_touch = touch_next;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			key_q <= req.key;
			val_q <= req.value;
		end
		eval_idx_s1 <= rd_addr;
		if (finish_go) begin
			rsp_hit_q     <= scan_res.hit;
			rsp_value_q   <= (!is_put && scan_res.hit) ? scan_res.match_ent.value : '0;
			rsp_evicted_q <= is_put && !scan_res.hit && full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= lfuc_pkg::CAP_RESET;
			touch_q     <= '0;
			occ_q       <= '0;
			valid_q     <= '0;
			eval_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			eval_s1 <= issue;
			if (wr_en) begin
				touch_q         <= touch_next;
				valid_q[wr_idx] <= 1'b1;
			end
			if (fill) begin
				occ_q <= occ_q + lfuc_pkg::CNT_W'(1);
			end
			if (finish_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.evicted    = rsp_evicted_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_lfu_cache_lru_tiebreak.sv @@
`default_nettype none

// Self-checking bench for the LFU cache with LRU tiebreak.
// A short table of hand-picked requests and capacity writes runs first.
// Randomized phases follow, each under its own capacity setting.
// Every request accepted on the request channel is run through a local
// model of the cache; the model's answer, or a typed row's own answer,
// is queued. Each response transfer is compared to the oldest queued one.
module tb_lfu_cache_lru_tiebreak;
	import lfuc_pkg::*;

	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 136;
	localparam int POOL_N       = 24;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int SETTLE       = 4;
	localparam int MAX_REPORTS  = 10;
	localparam int LIMIT_CYCLES = 1_000_000;

	// One response as the bench expects to see it.
	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
	} cache_rsp_t;

	// A row of the directed table either issues a request or writes the
	// capacity register (the data column then carries the new capacity).
	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic             act;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] data;
		bit               typed;
		cache_rsp_t       want;
	} stim_row_t;

	localparam int DIR_ROWS = 23;

	// Rows with the typed flag carry an answer that is obvious from the
	// empty cache; the rest are left to the model. The sequence walks a
	// get miss on an empty cache, all-zero and all-one keys and values, a
	// put that hits, capacity zero acting as one while two entries are held,
	// capacity above the slot count, and a capacity lowered under occupancy
	// where the least used, least recently touched entry must go.
	stim_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{ROW_REQ, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
		'{ROW_REQ, ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
		'{ROW_REQ, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 1'b0}},
		'{ROW_REQ, ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
		'{ROW_REQ, ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 1'b0}},
		'{ROW_REQ, ACT_PUT, 32'h0000_0000, 32'hA5A5_A5A5, 1'b1, '{1'b1, 32'h0, 1'b0}},
		'{ROW_REQ, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b1, 32'hA5A5_A5A5, 1'b0}},
		'{ROW_REQ, ACT_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
		'{ROW_CFG, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, ACT_PUT, 32'h0000_0005, 32'h1111_1111, 1'b0, '0},
		'{ROW_REQ, ACT_PUT, 32'h0000_0006, 32'h2222_2222, 1'b0, '0},
		'{ROW_REQ, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{ROW_CFG, ACT_GET, 32'h0000_0000, 32'h0000_001F, 1'b0, '0},
		'{ROW_REQ, ACT_PUT, 32'h0000_0007, 32'h3333_3333, 1'b0, '0},
		'{ROW_REQ, ACT_PUT, 32'h0000_0008, 32'h4444_4444, 1'b0, '0},
		'{ROW_CFG, ACT_GET, 32'h0000_0000, 32'h0000_0003, 1'b0, '0},
		'{ROW_REQ, ACT_PUT, 32'h0000_0009, 32'h5555_5555, 1'b0, '0},
		'{ROW_REQ, ACT_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, ACT_GET, 32'h0000_0008, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, ACT_PUT, 32'h0000_000A, 32'h6666_6666, 1'b0, '0},
		'{ROW_REQ, ACT_GET, 32'h0000_0009, 32'h0000_0000, 1'b0, '0},
		'{ROW_CFG, ACT_GET, 32'h0000_0000, 32'h0000_0010, 1'b0, '0},
		'{ROW_REQ, ACT_PUT, 32'h5A5A_5A5A, 32'h0000_0000, 1'b0, '0}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	lfuc_req_if req_bus ();
	lfuc_rsp_if rsp_bus ();

	lfu_cache_lru_tiebreak uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	always #1 clk = ~clk;

	// Local copy of the cache contents and bookkeeping.
	logic                cached_valid [CAPACITY];
	logic [KEY_W-1:0]    cached_key   [CAPACITY];
	logic [VAL_W-1:0]    cached_val   [CAPACITY];
	logic [USE_BITS-1:0] cached_uses  [CAPACITY];
	logic [TOUCH_W-1:0]  cached_stamp [CAPACITY];
	logic [TOUCH_W-1:0]  stamp_now;
	int                  filled_count;
	logic [CFG_W-1:0]    cap_setting;

	cache_rsp_t pending_rsp [$];
	int         fail_count = 0;
	int         cycle_count = 0;
	int         hold_asks = 0;
	logic [KEY_W-1:0] key_pool [POOL_N];

	// Computes the response to one request and updates the local cache.
	// Capacity is clamped to 1..CAPACITY. On a put miss with no room, the
	// victim is the valid entry with the lowest use count; among equal counts
	// the one touched longest ago (age taken modulo 2^32), then the lowest slot.
	function automatic cache_rsp_t predict_access(input logic act,
			input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
		cache_rsp_t          r;
		int                  eff_cap;
		int                  hit_slot;
		int                  free_slot;
		int                  slot;
		bit                  hit;
		bit                  have_free;
		bit                  found;
		logic [USE_BITS-1:0] best_use;
		logic [TOUCH_W-1:0]  age;
		logic [TOUCH_W-1:0]  best_age;

		eff_cap = int'(cap_setting);
		if (eff_cap < 1)
			eff_cap = 1;
		if (eff_cap > CAPACITY)
			eff_cap = CAPACITY;
		hit = 1'b0;
		have_free = 1'b0;
		hit_slot = 0;
		free_slot = 0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cached_valid[i]) begin
				if (!hit && cached_key[i] == k) begin
					hit = 1'b1;
					hit_slot = i;
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_slot = i;
			end
		end
		r.hit = hit;
		r.read_value = '0;
		r.evicted = 1'b0;
		if (hit) begin
			if (act == ACT_GET)
				r.read_value = cached_val[hit_slot];
			else
				cached_val[hit_slot] = v;
			if (cached_uses[hit_slot] != '1)
				cached_uses[hit_slot] = cached_uses[hit_slot] + 1'b1;
			stamp_now = stamp_now + 1'b1;
			cached_stamp[hit_slot] = stamp_now;
		end else if (act == ACT_PUT) begin
			if (filled_count >= eff_cap || !have_free) begin
				found = 1'b0;
				slot = 0;
				best_use = '0;
				best_age = '0;
				for (int i = 0; i < CAPACITY; i++) begin
					if (cached_valid[i]) begin
						age = stamp_now - cached_stamp[i];
						if (!found || cached_uses[i] < best_use ||
								(cached_uses[i] == best_use && age > best_age)) begin
							found = 1'b1;
							slot = i;
							best_use = cached_uses[i];
							best_age = age;
						end
					end
				end
				r.evicted = 1'b1;
			end else begin
				slot = free_slot;
				filled_count++;
			end
			cached_valid[slot] = 1'b1;
			cached_key[slot] = k;
			cached_val[slot] = v;
			cached_uses[slot] = USE_BITS'(1);
			stamp_now = stamp_now + 1'b1;
			cached_stamp[slot] = stamp_now;
		end
		return r;
	endfunction

	// Offers one request from a falling edge and holds it until the rising
	// edge where the transfer happens. Valid stays high on return, so a
	// following request goes out back to back; the model answer (or the typed
	// answer) is queued at the transfer. Returns on the next falling edge.
	task automatic send_req(input logic act, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, input bit typed, input cache_rsp_t want);
		cache_rsp_t guess;

		req_bus.valid <= 1'b1;
		req_bus.action <= act;
		req_bus.key <= k;
		req_bus.value <= v;
		do
			@(posedge clk);
		while (!req_bus.ready);
		guess = predict_access(act, k, v);
		pending_rsp.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	// Drops valid for a number of cycles; a zero-length gap leaves it alone.
	task automatic idle_gap(input int n);
		if (n > 0) begin
			req_bus.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// The capacity register must only change while the cache is idle, which the
	// block does not enforce, so the sender pauses until every outstanding response has been seen.
	task automatic write_capacity(input logic [CFG_W-1:0] cap);
		idle_gap(1);
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_setting = cap;
	endtask

	// Response checker: every response transfer is matched in order
	// against the queued model answers.
	always @(posedge clk) begin : rsp_check
		cache_rsp_t want;

		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_rsp.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected response: hit=%0b read_value=%h evicted=%0b",
						rsp_bus.hit, rsp_bus.read_value, rsp_bus.evicted);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_bus.hit !== want.hit || rsp_bus.read_value !== want.read_value ||
						rsp_bus.evicted !== want.evicted) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("mismatch: expected hit=%0b read_value=%h evicted=%0b, %s%0b %h %0b",
							want.hit, want.read_value, want.evicted, "got ",
							rsp_bus.hit, rsp_bus.read_value, rsp_bus.evicted);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Response side: ready follows a pattern that changes after each random
	// span (always ready, coin flip, mostly stalled, mostly ready). On
	// request from the sender it holds off for a long stretch so that the
	// response register fills and the request channel backs up.
	initial begin : rsp_ready_gen
		int mode;
		int span;
		int hold_seen;

		rsp_bus.ready = 1'b0;
		hold_seen = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 60);
			repeat (span) begin
				@(negedge clk);
				if (hold_asks != hold_seen) begin
					hold_seen = hold_asks;
					rsp_bus.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end else begin
					case (mode)
						0: rsp_bus.ready <= 1'b1;
						1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
						2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
						default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain, verdict.
	initial begin : stim_main
		int               burst_left;
		int               pool_top;
		int               eff;
		logic             act;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		logic [CFG_W-1:0] cap_pick;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = CAP_RESET;
		req_bus.valid = 1'b0;
		req_bus.action = ACT_GET;
		req_bus.key = '0;
		req_bus.value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			cached_valid[i] = 1'b0;
			cached_key[i] = '0;
			cached_val[i] = '0;
			cached_uses[i] = '0;
			cached_stamp[i] = '0;
		end
		stamp_now = '0;
		filled_count = 0;
		cap_setting = CAP_RESET;

		// The pool gives the random phases a working set of keys that
		// keeps coming back, so hits and evictions both happen often.
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			key_pool[i] = $urandom;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_capacity(dir_rows[i].data[CFG_W-1:0]);
			end else begin
				send_req(dir_rows[i].act, dir_rows[i].key, dir_rows[i].data,
					dir_rows[i].typed, dir_rows[i].want);
				idle_gap($urandom_range(0, 2));
			end
		end

		// Random phases. The first few pin the capacity to its corners
		// (one, full, zero, out of range, two); later ones pick at random.
		// Requests go out in bursts of random length separated by random
		// gaps, with some bursts running straight into the next.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: cap_pick = CFG_W'(1);
				1: cap_pick = CFG_W'(16);
				2: cap_pick = CFG_W'(0);
				3: cap_pick = CFG_W'(31);
				4: cap_pick = CFG_W'(2);
				default: cap_pick = CFG_W'($urandom_range(0, 31));
			endcase
			write_capacity(cap_pick);
			eff = int'(cap_pick);
			if (eff < 1)
				eff = 1;
			if (eff > CAPACITY)
				eff = CAPACITY;
			pool_top = (eff + 5 < POOL_N) ? eff + 5 : POOL_N - 1;
			burst_left = $urandom_range(1, 12);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				act = ($urandom_range(0, 1) == 1) ? ACT_PUT : ACT_GET;
				if ($urandom_range(0, 4) == 0)
					k = $urandom;
				else
					k = key_pool[$urandom_range(0, pool_top)];
				v = $urandom;
				if (phase == 2 && n == 40)
					hold_asks++;
				send_req(act, k, v, 1'b0, '0);
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					if ($urandom_range(0, 3) != 0)
						idle_gap($urandom_range(1, 40));
				end
			end
		end

		// Drain: wait for every outstanding response, then let the block
		// sit a little longer so a stray extra response would be caught.
		idle_gap(1);
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_rsp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

@@ lfu_cache_lru_tiebreak.f @@
rtl/lfuc_pkg.sv
rtl/lfuc_if.sv
rtl/lfuc_ram.sv
rtl/lfuc_scan.sv
rtl/lfuc_seq.sv
rtl/lfu_cache_lru_tiebreak.sv
tb/sv/tb_lfu_cache_lru_tiebreak.sv
